// ----- sv/msbs_pkg.sv -----
`default_nettype none

package msbs_pkg;

   // Table and stream sizes.
   localparam int NUM_SIGS     = 16;
   localparam int MAX_SIG_LEN  = 64;
   localparam int MAX_SCAN_LEN = 16384;

   // Derived widths.
   localparam int SIG_W  = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
   localparam int CNT_W  = $clog2(NUM_SIGS + 1);
   localparam int POS_W  = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
   localparam int LPOS_W = $clog2(MAX_SIG_LEN + 1);
   localparam int SPOS_W = $clog2(MAX_SCAN_LEN + 1);

   // Fixed widths of the result fields.
   localparam int IDX_W = 4;
   localparam int OFF_W = 14;
   localparam int LEN_W = 7;

   // Item kinds.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_SCAN  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       final_req;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] sig_index;
      logic [OFF_W-1:0] start_offset;
      logic [LEN_W-1:0] sig_length;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_EMIT
   } state_type;

   // Signals shared by every cell of a signature row.
   typedef struct packed {
      logic             fresh;
      logic             start;
      logic [7:0]       scan_byte;
      logic [POS_W-1:0] wr_pos;
      logic [7:0]       wr_data;
   } row_ctrl_type;

endpackage

`default_nettype wire

// ----- sv/msbs_cell.sv -----
`default_nettype none

// One signature byte and the flag that the signature prefix ending at
// this byte matches the newest stream bytes.
module msbs_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire msbs_pkg::row_ctrl_type ctrl,
   input  wire logic                  step,
   input  wire logic                  wr_en,
   input  wire logic                  prev_active,
   output logic                       active
);

   logic [7:0] sig_ff;
   logic [7:0] sig_in;
   logic       active_ff;
   logic       active_in;

   always_comb begin
      sig_in = sig_ff;
      if (wr_en) begin
         sig_in = ctrl.wr_data;
      end
   end

   always_comb begin
      active_in = active_ff;
      if (step) begin
         active_in = prev_active && (sig_ff == ctrl.scan_byte);
      end
   end

   always_ff @(posedge clock) begin
      sig_ff <= sig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule

`default_nettype wire

// ----- sv/msbs_row.sv -----
`default_nettype none

// A chain of cells holding one signature. Each step hands the match flag
// one cell further along while every cell compares the broadcast byte.
module msbs_row (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msbs_pkg::row_ctrl_type        ctrl,
   input  wire logic                          step,
   input  wire logic                          wr_en,
   output logic [msbs_pkg::MAX_SIG_LEN-1:0]   active
);

   logic [msbs_pkg::MAX_SIG_LEN-1:0] prev;

   always_comb begin
      prev[0] = ctrl.start;
      for (int j = 1; j < msbs_pkg::MAX_SIG_LEN; j++) begin
         prev[j] = active[j-1] && !ctrl.fresh;
      end
   end

   for (genvar j = 0; j < msbs_pkg::MAX_SIG_LEN; j++) begin : g_cell
      msbs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .step        (step),
         .wr_en       (wr_en && (ctrl.wr_pos == msbs_pkg::POS_W'(j))),
         .prev_active (prev[j]),
         .active      (active[j])
      );
   end

endmodule

`default_nettype wire

// ----- sv/multi_signature_byte_scanner.sv -----
`default_nettype none

// Multi-signature byte scanner.
// Input channel (req_*): one transfer carries a kind, a byte and a final
// flag. Kind load appends a byte to the pending signature, and final
// commits it; kind scan feeds one stream byte, and final ends the stream;
// kind clear empties the table. Result channel (rsp_*): one transfer per
// match, signature index, start offset within the stream and length, with
// last set on the final report of a scanned byte. Reports of one byte come
// highest index first.
// Scan bytes without matches stream at one per cycle while no replay or
// report holds the input. A scan byte with matches holds the input while
// its match flags, registered in the cells, go into the pending set and
// then one at a time into the output register. A committing load holds
// the input while the new row replays the recent-byte line, one byte a
// cycle. Reset empties the table and starts a new stream. A stall on the
// result channel holds the current report and, in turn, the input.
module multi_signature_byte_scanner (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire msbs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output msbs_pkg::rsp_type      rsp_data
);

   localparam int M = msbs_pkg::MAX_SIG_LEN;
   localparam int N = msbs_pkg::NUM_SIGS;

   msbs_pkg::state_type state_ff, state_in;

   // Signature table bookkeeping.
   logic [msbs_pkg::CNT_W-1:0]  sig_count_ff, sig_count_in;
   logic [msbs_pkg::LPOS_W-1:0] load_pos_ff, load_pos_in;
   logic                        load_ovf_ff, load_ovf_in;
   logic [msbs_pkg::LPOS_W-1:0] len_ff [N];
   logic [msbs_pkg::LPOS_W-1:0] len_in [N];

   // Stream state: position and the newest bytes, newest at index 0.
   logic [msbs_pkg::SPOS_W-1:0] scan_pos_ff, scan_pos_in;
   logic [7:0]                  recent_ff [M];
   logic [7:0]                  recent_in [M];

   // Replay sweep of a freshly committed row.
   logic [msbs_pkg::POS_W-1:0]  rc_ff, rc_in;
   logic [msbs_pkg::SIG_W-1:0]  replay_row_ff, replay_row_in;

   // Match collection and report queue.
   logic                        scan_done_ff, scan_done_in;
   logic [msbs_pkg::SPOS_W-1:0] snap_pos_ff, snap_pos_in;
   logic [N-1:0]                pend_ff, pend_in;
   logic [msbs_pkg::SPOS_W-1:0] pend_pos_ff, pend_pos_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   msbs_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Row interface.
   msbs_pkg::row_ctrl_type      row_ctrl;
   logic [M-1:0]                active_vec [N];
   logic [N-1:0]                row_step;
   logic [N-1:0]                row_wr;
   logic [N-1:0]                hit;
   logic                        any_hit;

   // Decoded item and control.
   logic                        req_accept;
   logic                        is_load, is_scan, is_clear;
   logic                        table_full;
   logic                        load_wr;
   logic [msbs_pkg::LPOS_W-1:0] pos_after;
   logic                        ovf_after;
   logic                        commit;
   logic                        scan_step;
   logic                        replay_step;
   logic                        capture;
   logic                        emit_go;
   logic [msbs_pkg::SIG_W-1:0]  sel;
   logic [N-1:0]                sel_mask;
   logic                        emit_last;

   assign req_accept = req_valid && !req_stall;

   // Item decode.
   always_comb begin
      is_load  = 1'b0;
      is_scan  = 1'b0;
      is_clear = 1'b0;
      case (req_data.kind)
         msbs_pkg::KIND_LOAD:  is_load  = req_accept;
         msbs_pkg::KIND_SCAN:  is_scan  = req_accept;
         msbs_pkg::KIND_CLEAR: is_clear = req_accept;
         default: ;
      endcase
   end

   // A load byte is stored while the table has room and the pending
   // signature still fits; a byte beyond the limit marks it overlong.
   always_comb begin
      table_full = (sig_count_ff == msbs_pkg::CNT_W'(N));
      load_wr    = is_load && !table_full && !load_ovf_ff &&
                   (load_pos_ff < msbs_pkg::LPOS_W'(M));
      pos_after  = load_wr ? load_pos_ff + 1'b1 : load_pos_ff;
      ovf_after  = load_ovf_ff || (is_load && !table_full && !load_wr);
      commit     = is_load && req_data.final_req && !table_full && !ovf_after &&
                   (pos_after != '0);
      scan_step  = is_scan && (scan_pos_ff < msbs_pkg::SPOS_W'(msbs_pkg::MAX_SCAN_LEN));
   end

   // State machine outputs.
   always_comb begin
      req_stall   = 1'b1;
      replay_step = 1'b0;
      capture     = 1'b0;
      emit_go     = 1'b0;
      case (state_ff)
         msbs_pkg::ST_IDLE: begin
            req_stall = scan_done_ff && any_hit;
            capture   = scan_done_ff && any_hit;
         end
         msbs_pkg::ST_REPLAY: begin
            replay_step = 1'b1;
         end
         msbs_pkg::ST_EMIT: begin
            emit_go = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // State machine next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msbs_pkg::ST_IDLE: begin
            if (commit) begin
               state_in = msbs_pkg::ST_REPLAY;
            end else if (scan_done_ff && any_hit) begin
               state_in = msbs_pkg::ST_EMIT;
            end
         end
         msbs_pkg::ST_REPLAY: begin
            if (rc_ff == '0) begin
               state_in = msbs_pkg::ST_IDLE;
            end
         end
         msbs_pkg::ST_EMIT: begin
            if (emit_go && emit_last) begin
               state_in = msbs_pkg::ST_IDLE;
            end
         end
         default: state_in = msbs_pkg::ST_IDLE;
      endcase
   end

   // During a replay the oldest byte of the line is fed to the new row, and
   // the chain may only start at bytes that belong to the current stream.
   // The first byte of a stream starts every chain afresh.
   always_comb begin
      row_ctrl.scan_byte = replay_step ? recent_ff[M-1] : req_data.data_byte;
      row_ctrl.fresh     = !replay_step && (scan_pos_ff == '0);
      row_ctrl.start     = replay_step ? (msbs_pkg::SPOS_W'(rc_ff) < scan_pos_ff) : 1'b1;
      row_ctrl.wr_pos    = load_pos_ff[msbs_pkg::POS_W-1:0];
      row_ctrl.wr_data   = req_data.data_byte;
      for (int s = 0; s < N; s++) begin
         row_step[s] = scan_step ||
                       (replay_step && (replay_row_ff == msbs_pkg::SIG_W'(s)));
         row_wr[s]   = load_wr &&
                       (sig_count_ff[msbs_pkg::SIG_W-1:0] == msbs_pkg::SIG_W'(s));
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_row
      msbs_row u_row (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (row_ctrl),
         .step   (row_step[s]),
         .wr_en  (row_wr[s]),
         .active (active_vec[s])
      );
   end

   // A committed signature matches when the flag of its last byte is set.
   always_comb begin
      logic [msbs_pkg::LPOS_W-1:0] lm1;
      for (int s = 0; s < N; s++) begin
         lm1    = len_ff[s] - 1'b1;
         hit[s] = (msbs_pkg::CNT_W'(s) < sig_count_ff) &&
                  active_vec[s][lm1[msbs_pkg::POS_W-1:0]];
      end
      any_hit = |hit;
   end

   // Highest pending index goes out first.
   always_comb begin
      sel = '0;
      for (int s = 0; s < N; s++) begin
         if (pend_ff[s]) begin
            sel = msbs_pkg::SIG_W'(s);
         end
      end
      sel_mask      = '0;
      sel_mask[sel] = 1'b1;
      emit_last     = ((pend_ff & ~sel_mask) == '0);
   end

   // Register next values.
   always_comb begin
      sig_count_in  = sig_count_ff;
      load_pos_in   = load_pos_ff;
      load_ovf_in   = load_ovf_ff;
      len_in        = len_ff;
      scan_pos_in   = scan_pos_ff;
      recent_in     = recent_ff;
      rc_in         = rc_ff;
      replay_row_in = replay_row_ff;
      scan_done_in  = scan_step;
      snap_pos_in   = snap_pos_ff;
      pend_in       = pend_ff;
      pend_pos_in   = pend_pos_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (is_load) begin
         load_pos_in = pos_after;
         load_ovf_in = ovf_after;
         if (req_data.final_req) begin
            load_pos_in = '0;
            load_ovf_in = 1'b0;
         end
         if (commit) begin
            for (int s = 0; s < N; s++) begin
               if (sig_count_ff[msbs_pkg::SIG_W-1:0] == msbs_pkg::SIG_W'(s)) begin
                  len_in[s] = pos_after;
               end
            end
            sig_count_in  = sig_count_ff + 1'b1;
            replay_row_in = sig_count_ff[msbs_pkg::SIG_W-1:0];
            rc_in         = msbs_pkg::POS_W'(M - 1);
         end
      end

      if (is_clear) begin
         sig_count_in = '0;
         load_pos_in  = '0;
         load_ovf_in  = 1'b0;
         for (int s = 0; s < N; s++) begin
            len_in[s] = '0;
         end
      end

      if (scan_step) begin
         recent_in[0] = req_data.data_byte;
         for (int k = 1; k < M; k++) begin
            recent_in[k] = recent_ff[k-1];
         end
         scan_pos_in = scan_pos_ff + 1'b1;
         snap_pos_in = scan_pos_ff + 1'b1;
      end
      if (is_scan && req_data.final_req) begin
         scan_pos_in = '0;
      end

      // The line turns once around during a replay and ends as it began.
      if (replay_step) begin
         recent_in[0] = recent_ff[M-1];
         for (int k = 1; k < M; k++) begin
            recent_in[k] = recent_ff[k-1];
         end
         rc_in = rc_ff - 1'b1;
      end

      if (capture) begin
         pend_in     = hit;
         pend_pos_in = snap_pos_ff;
      end

      if (emit_go) begin
         pend_in                  = pend_ff & ~sel_mask;
         rsp_valid_in             = 1'b1;
         rsp_data_in.sig_index    = msbs_pkg::IDX_W'(sel);
         rsp_data_in.start_offset = msbs_pkg::OFF_W'(pend_pos_ff -
                                    msbs_pkg::SPOS_W'(len_ff[sel]));
         rsp_data_in.sig_length   = msbs_pkg::LEN_W'(len_ff[sel]);
         rsp_data_in.last         = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msbs_pkg::ST_IDLE;
         sig_count_ff  <= '0;
         load_pos_ff   <= '0;
         load_ovf_ff   <= 1'b0;
         for (int s = 0; s < N; s++) begin
            len_ff[s] <= '0;
         end
         scan_pos_ff   <= '0;
         rc_ff         <= '0;
         replay_row_ff <= '0;
         scan_done_ff  <= 1'b0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sig_count_ff  <= sig_count_in;
         load_pos_ff   <= load_pos_in;
         load_ovf_ff   <= load_ovf_in;
         len_ff        <= len_in;
         scan_pos_ff   <= scan_pos_in;
         rc_ff         <= rc_in;
         replay_row_ff <= replay_row_in;
         scan_done_ff  <= scan_done_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      recent_ff   <= recent_in;
      snap_pos_ff <= snap_pos_in;
      pend_pos_ff <= pend_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/msbs_checker.sv -----
`default_nettype none

module msbs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire msbs_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire msbs_pkg::rsp_type rsp_data
);

   // A stalled report stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled report changed");

   // Reports always carry a real signature length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sig_length != '0) &&
                    (int'(rsp_data.sig_length) <= msbs_pkg::MAX_SIG_LEN))
      else $error("report length out of range");

   // More reports of the same byte are due, so no new item may enter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input taken while a byte still has reports pending");

   // Reset leaves no report behind.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report valid after reset");

endmodule

bind multi_signature_byte_scanner msbs_checker u_msbs_checker (.*);

`default_nettype wire

// ----- dv/multi_signature_byte_scanner_tb.sv -----
`default_nettype none

// Self-checking testbench for the multi-signature byte scanner.
//
// The initial block runs named tests in turn. Each test builds load, scan
// and clear items and hands them to send_item, which performs one transfer
// on the input channel. At the edge where the transfer happens, the item is
// applied to a signature-table model kept in this file, and the reports that
// it must cause are appended to expected_reports. A separate process
// compares every transfer on the result channel against the oldest entry
// of that queue, field by field.
module multi_signature_byte_scanner_tb;

   // Kind 3 has no meaning. The block must ignore it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Input items in the whole run. The random test tops the directed tests
   // up to this count.
   localparam int ITEMS_TOTAL = 270;

   // The run sends a little under 300 items. Each of them costs at most an
   // idle gap plus either a signature commit or 16 reports that may each be
   // stalled. The limit is set well above what such a run can take.
   localparam int LIMIT_CYCLES  = 200_000;
   localparam int DRAIN_LIMIT   = 5_000;
   // A commit replays the whole recent-byte line, so wait a bit past that
   // for stray reports after the last expected one.
   localparam int SETTLE_CYCLES = msbs_pkg::MAX_SIG_LEN + 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   msbs_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   msbs_pkg::rsp_type rsp_data;

   multi_signature_byte_scanner DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Signature-table model: the table, the pending signature and the
   // scan-stream state, all as they stand after the last accepted item.
   // ------------------------------------------------------------------
   bit [7:0]    sig_mem [msbs_pkg::NUM_SIGS][msbs_pkg::MAX_SIG_LEN];
   int unsigned sig_len_tab [msbs_pkg::NUM_SIGS];
   int unsigned sigs_held;
   int unsigned pend_len;
   bit          pend_overlong;
   bit [7:0]    history [msbs_pkg::MAX_SIG_LEN];   // newest scanned byte at index 0
   int unsigned stream_pos;

   msbs_pkg::rsp_type expected_reports [$];

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned scans_sent;
   int unsigned reports_checked;
   int unsigned busiest_byte;

   // These flags switch on stretches where the matching side never idles.
   bit          tx_steady;
   bit          rx_steady;

   // The random test draws most of its bytes from a few values, so that
   // scanned bytes often complete signatures.
   logic [7:0]  palette [4];

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   // Apply one accepted item to the model and queue the reports it causes.
   function automatic void predict_item(input msbs_pkg::req_type item);
      msbs_pkg::rsp_type found [$];
      msbs_pkg::rsp_type one;
      int unsigned       len;
      bit                hit;
      case (item.kind)
         msbs_pkg::KIND_LOAD: begin
            // Once the table is full, load bytes are dropped. The final flag
            // still closes the pending signature.
            if (sigs_held < msbs_pkg::NUM_SIGS) begin
               if (pend_len < msbs_pkg::MAX_SIG_LEN && !pend_overlong) begin
                  sig_mem[sigs_held][pend_len] = item.data_byte;
                  pend_len++;
               end else begin
                  pend_overlong = 1'b1;
               end
            end
            if (item.final_req) begin
               if (sigs_held < msbs_pkg::NUM_SIGS && !pend_overlong && pend_len > 0) begin
                  sig_len_tab[sigs_held] = pend_len;
                  sigs_held++;
               end
               pend_len      = 0;
               pend_overlong = 1'b0;
            end
         end
         msbs_pkg::KIND_SCAN: begin
            scans_sent++;
            // Bytes past the offset limit leave the stream untouched.
            if (stream_pos < msbs_pkg::MAX_SCAN_LEN) begin
               for (int i = msbs_pkg::MAX_SIG_LEN - 1; i > 0; i--) begin
                  history[i] = history[i-1];
               end
               history[0] = item.data_byte;
               stream_pos++;
               // Newest signature first. Only signatures that fit wholly
               // inside the current stream can match.
               for (int s = int'(sigs_held) - 1; s >= 0; s--) begin
                  len = sig_len_tab[s];
                  if (len == 0 || len > stream_pos) begin
                     continue;
                  end
                  hit = 1'b1;
                  for (int j = 0; j < int'(len); j++) begin
                     if (sig_mem[s][j] != history[len-1-j]) begin
                        hit = 1'b0;
                     end
                  end
                  if (hit) begin
                     one.sig_index    = s[msbs_pkg::IDX_W-1:0];
                     one.start_offset = msbs_pkg::OFF_W'(stream_pos - len);
                     one.sig_length   = msbs_pkg::LEN_W'(len);
                     one.last         = 1'b0;
                     found.push_back(one);
                  end
               end
               if (found.size() > 0) begin
                  found[found.size()-1].last = 1'b1;
               end
               if (found.size() > busiest_byte) begin
                  busiest_byte = found.size();
               end
               foreach (found[i]) begin
                  expected_reports.push_back(found[i]);
               end
            end
            if (item.final_req) begin
               stream_pos = 0;
            end
         end
         msbs_pkg::KIND_CLEAR: begin
            // The table empties, but the scan stream carries on.
            foreach (sig_len_tab[i]) begin
               sig_len_tab[i] = 0;
            end
            sigs_held     = 0;
            pend_len      = 0;
            pend_overlong = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Input side. One call makes one transfer. The valid signal is left
   // high after a transfer, so back-to-back items never lower and raise
   // it in the same time step. Each item may first wait with valid low,
   // except while the input side runs steady.
   // ------------------------------------------------------------------
   task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                            input logic fin);
      int                gap;
      msbs_pkg::req_type item;
      if ($urandom_range(0, 15) == 0) begin
         tx_steady = !tx_steady;
      end
      gap = tx_steady ? 0 : $urandom_range(0, 3);
      item.kind      = kind;
      item.data_byte = value;
      item.final_req = fin;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(item);
      items_sent++;
   endtask

   // Load one signature, with the final flag on its last byte.
   task automatic load_signature(input logic [7:0] word [$]);
      foreach (word[i]) begin
         send_item(msbs_pkg::KIND_LOAD, word[i], i == word.size() - 1);
      end
   endtask

   // Scan a run of bytes. The final flag may be set on the last one.
   task automatic scan_run(input logic [7:0] word [$], input logic end_stream);
      foreach (word[i]) begin
         send_item(msbs_pkg::KIND_SCAN, word[i], end_stream && (i == word.size() - 1));
      end
   endtask

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(0, 7) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return palette[$urandom_range(0, 3)];
   endfunction

   // ------------------------------------------------------------------
   // Result side. Before each transfer, the stall may first be raised,
   // except while the result side runs steady, then kept low until the transfer happens.
   // ------------------------------------------------------------------
   initial begin : result_sink
      int hold;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rx_steady = !rx_steady;
         end
         hold = rx_steady ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Every transfer on the result channel is checked against the oldest
   // expected report. Values are taken as they stood just before the edge.
   always @(posedge clock) begin
      msbs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            note_error($sformatf("unexpected report: index %0d offset %0d length %0d last %0b",
                                 rsp_data.sig_index, rsp_data.start_offset,
                                 rsp_data.sig_length, rsp_data.last));
         end else begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (rsp_data.sig_index !== want.sig_index ||
                rsp_data.start_offset !== want.start_offset ||
                rsp_data.sig_length !== want.sig_length ||
                rsp_data.last !== want.last) begin
               note_error($sformatf({"report mismatch: expected index %0d offset %0d ",
                                     "length %0d last %0b, got index %0d offset %0d ",
                                     "length %0d last %0b"},
                                    want.sig_index, want.start_offset, want.sig_length,
                                    want.last, rsp_data.sig_index, rsp_data.start_offset,
                                    rsp_data.sig_length, rsp_data.last));
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Run stopped after %0d cycles with %0d reports outstanding.",
                  cycle_count, expected_reports.size());
         $display("** multi_signature_byte_scanner: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Sixteen one-byte signatures fill the table, and one scanned byte then
   // completes all of them at once. Loads into a full table, final or
   // not, must change nothing.
   task automatic test_full_table();
      logic [7:0] word [$];
      word = {8'hFF};
      repeat (msbs_pkg::NUM_SIGS) load_signature(word);
      send_item(msbs_pkg::KIND_LOAD, 8'h00, 1'b0);
      send_item(msbs_pkg::KIND_LOAD, 8'h7E, 1'b1);
      word = {8'hFF};
      scan_run(word, 1'b1);
      word = {8'h00, 8'hFF};
      scan_run(word, 1'b1);
   endtask

   // A signature one byte over the maximum length is dropped, and one of
   // the maximum length matches on the byte that ends the stream. The
   // overlong one is loaded first: if the block kept it, the longest
   // signature would report under the wrong index.
   task automatic test_long_signatures();
      logic [7:0] longest [$];
      logic [7:0] word [$];
      send_item(msbs_pkg::KIND_CLEAR, 8'h00, 1'b0);
      for (int i = 0; i < msbs_pkg::MAX_SIG_LEN; i++) begin
         longest.push_back(8'(i * 37 + 5));
      end
      word = longest;
      word.push_back(8'hA5);
      load_signature(word);
      load_signature(longest);
      scan_run(longest, 1'b1);
   endtask

   // A signature cut short by a clear is lost. The scan stream and its
   // offsets carry on across the clear.
   task automatic test_clear_and_stream();
      logic [7:0] word [$];
      send_item(msbs_pkg::KIND_CLEAR, 8'hFF, 1'b1);
      send_item(msbs_pkg::KIND_LOAD, 8'hC3, 1'b0);
      send_item(msbs_pkg::KIND_LOAD, 8'h3C, 1'b0);
      send_item(msbs_pkg::KIND_CLEAR, 8'h00, 1'b0);
      word = {8'h3C};
      load_signature(word);
      word = {8'hC3, 8'h3C};
      scan_run(word, 1'b0);
      send_item(msbs_pkg::KIND_CLEAR, 8'h00, 1'b0);
      word = {8'h3C};
      scan_run(word, 1'b0);
      word = {8'h3C, 8'h3C};
      load_signature(word);
      scan_run(word, 1'b1);
   endtask

   // Kind 3 must be ignored whatever its byte and final flag are.
   task automatic test_unused_kind();
      logic [7:0] word [$];
      send_item(KIND_UNUSED, 8'hFF, 1'b1);
      send_item(KIND_UNUSED, 8'h00, 1'b0);
      send_item(KIND_UNUSED, 8'h3C, 1'b1);
      word = {8'h3C, 8'h3C};
      scan_run(word, 1'b1);
   endtask

   // Short signatures loaded from a small set of byte values, and scan runs
   // that embed copies of stored signatures between noise bytes. Mixed in
   // are clears, some of them cutting a load short, loads into a full
   // table, stream ends and kind 3 items. Runs until the item count of the
   // whole run is reached.
   task automatic test_random_traffic();
      logic [7:0] word [$];
      int         pick;
      int         n;
      int         s;
      foreach (palette[i]) begin
         palette[i] = 8'($urandom_range(0, 255));
      end
      while (items_sent < ITEMS_TOTAL) begin
         pick = $urandom_range(0, 99);
         if (sigs_held == msbs_pkg::NUM_SIGS && $urandom_range(0, 5) == 0) begin
            pick = 26;
         end
         word.delete();
         if (pick < 25) begin
            n = $urandom_range(1, 4);
            repeat (n) word.push_back(noise_byte());
            load_signature(word);
         end else if (pick < 28) begin
            if ($urandom_range(0, 1) == 1) begin
               n = $urandom_range(1, 3);
               repeat (n) send_item(msbs_pkg::KIND_LOAD, noise_byte(), 1'b0);
            end
            send_item(msbs_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 30) begin
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(0, 2)) word.push_back(noise_byte());
            if (sigs_held > 0 && $urandom_range(0, 2) != 0) begin
               s = $urandom_range(0, sigs_held - 1);
               for (int j = 0; j < int'(sig_len_tab[s]); j++) begin
                  word.push_back(sig_mem[s][j]);
               end
            end
            repeat ($urandom_range(0, 3)) word.push_back(noise_byte());
            if (word.size() == 0) begin
               word.push_back(noise_byte());
            end
            scan_run(word, $urandom_range(0, 7) == 0);
         end
      end
   endtask

   // Stop driving, let every expected report come in, then wait a little
   // longer so that any report the block adds on its own is caught.
   task automatic drain_reports();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         note_error($sformatf("%0d expected reports never arrived",
                              expected_reports.size()));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_full_table();
      test_long_signatures();
      test_clear_and_stream();
      test_unused_kind();
      test_random_traffic();
      drain_reports();

      $display("Covered %0d input transfers (%0d scanned bytes) in %0d cycles.",
               items_sent, scans_sent, cycle_count);
      $display("Checked %0d match reports, up to %0d from a single byte; %0d errors.",
               reports_checked, busiest_byte, error_count);
      if (error_count == 0) begin
         $display("** multi_signature_byte_scanner: PASSED **");
      end else begin
         $display("** multi_signature_byte_scanner: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
